[design/asis_pkg.sv]
package asis_pkg;

	localparam int INSTR_W     = 32;
	localparam int WORD_W      = 32;
	localparam int REG_AW      = 4;
	localparam int REGS        = 16;
	localparam int BANK_WORDS  = 1024;
	localparam int BANKS       = 16;
	localparam int BANK_AW     = $clog2(BANK_WORDS);
	localparam int STORE_WORDS = BANKS * BANK_WORDS;
	localparam int STORE_AW    = $clog2(STORE_WORDS);

	// Output tdata layout, from the lowest bit up.
	localparam int OUT_PC_LSB  = 0;
	localparam int OUT_IDX_LSB = OUT_PC_LSB + WORD_W;
	localparam int OUT_VAL_LSB = OUT_IDX_LSB + REG_AW;
	localparam int OUT_USED_W  = OUT_VAL_LSB + WORD_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	localparam logic [WORD_W-1:0] EXIT_WORD = 32'hef00_0011;
	localparam logic [WORD_W-1:0] SP_RESET  = 32'd1000;
	localparam logic [REG_AW-1:0] SP_INDEX  = 4'd13;
	localparam logic [REG_AW-1:0] PC_INDEX  = 4'd15;
	localparam logic [REG_AW-1:0] ZERO_INDEX = 4'd0;

	// Instruction classes, bits 27:26.
	localparam logic [1:0] CLS_DP  = 2'd0;
	localparam logic [1:0] CLS_MEM = 2'd1;
	localparam logic [1:0] CLS_BR  = 2'd2;

	// Data-processing opcodes, bits 24:21.
	localparam logic [3:0] OP_AND = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_ADD = 4'd4;
	localparam logic [3:0] OP_CMP = 4'd10;
	localparam logic [3:0] OP_ORR = 4'd12;
	localparam logic [3:0] OP_MOV = 4'd13;
	localparam logic [3:0] OP_MVN = 4'd15;

	// Load/store opcodes, bits 25:20.
	localparam logic [5:0] LS_STORE = 6'd24;
	localparam logic [5:0] LS_LOAD  = 6'd25;

	// Branch conditions, bits 31:28.
	localparam logic [3:0] COND_EQ = 4'd0;
	localparam logic [3:0] COND_NE = 4'd1;
	localparam logic [3:0] COND_GE = 4'd10;
	localparam logic [3:0] COND_LT = 4'd11;
	localparam logic [3:0] COND_GT = 4'd12;
	localparam logic [3:0] COND_LE = 4'd13;
	localparam logic [3:0] COND_AL = 4'd14;

endpackage

[design/arm_subset_instruction_step.sv]
// An instruction enters the execute stage register on its input transfer and executes there;
// its result is registered into the output register, which offers it on m_axis.
// Throughput: one instruction per cycle unless m_axis stalls; execute stage reads the registered
// ports of the register file and data store RAMs, with bypasses from the instruction ahead of it.
// Reset: arst_n clears the control state; R13 reads 1000 and R0-R12, R14 read 0 until written.
// After reset the data store is swept to zero, all 16384 words, with s_axis_tready held low.
module arm_subset_instruction_step (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [asis_pkg::INSTR_W-1:0]        s_axis_tdata,  // [31:0] instruction
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] next_fetch_address, [35:32] written_index, [67:36] written_value, [71:68] zero
	output logic [asis_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tuser,  // [0] register_written
	output logic                                m_axis_tlast   // stopped
);

	localparam int W   = asis_pkg::WORD_W;
	localparam int RAW = asis_pkg::REG_AW;
	localparam int SAW = asis_pkg::STORE_AW;
	localparam int BAW = asis_pkg::BANK_AW;
	localparam int PADW = asis_pkg::OUT_TDATA_W - asis_pkg::OUT_USED_W;

	function automatic logic [W-1:0] reset_value(input logic [RAW-1:0] idx);
		return (idx == asis_pkg::SP_INDEX) ? asis_pkg::SP_RESET : '0;
	endfunction

	function automatic logic [W-1:0] operand(
		input logic [RAW-1:0] idx,
		input logic           byp,
		input logic           vld,
		input logic [W-1:0]   ram,
		input logic [W-1:0]   byp_val,
		input logic [W-1:0]   pc1
	);
		logic [W-1:0] v;
		if (idx == asis_pkg::PC_INDEX) begin
			v = pc1;
		end else if (byp) begin
			v = byp_val;
		end else if (vld) begin
			v = ram;
		end else begin
			v = reset_value(idx);
		end
		return v;
	endfunction

	// Control and architectural state.
	logic           s1_valid_q;
	logic           out_valid_q;
	logic [W-1:0]   pc_q;
	logic           n_q;
	logic           z_q;
	logic [asis_pkg::REGS-1:0] rf_valid_q;
	logic           clr_busy_q;
	logic [SAW-1:0] clr_cnt_q;

	// Execute stage.
	logic [W-1:0]   instr_s1;
	logic           vld_a_s1;
	logic           vld_b_s1;
	logic           byp_a_s1;
	logic           byp_b_s1;
	logic [W-1:0]   byp_val_s1;
	logic           st_byp_s1;
	logic [W-1:0]   st_byp_val_s1;

	// Output register.
	logic [asis_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic           out_user_q;
	logic           out_last_q;

	logic           fire;
	logic           accept;

	// Decode of the incoming word, for the RAM read addresses.
	logic [1:0]     in_cls;
	logic [RAW-1:0] in_addr_a;
	logic [RAW-1:0] in_addr_b;
	logic [SAW-1:0] in_dm_addr;

	// Decode of the word in execute.
	logic [1:0]     cls;
	logic [RAW-1:0] rn;
	logic [RAW-1:0] rd;
	logic [RAW-1:0] rm;
	logic [RAW-1:0] addr_a;
	logic [3:0]     op_dp;
	logic [5:0]     op_ls;
	logic [3:0]     cond;
	logic [SAW-1:0] dm_addr;

	logic [W-1:0]   rf_a_rdata;
	logic [W-1:0]   rf_b_rdata;
	logic [W-1:0]   dm_rdata;
	logic [W-1:0]   pc_plus1;
	logic [W-1:0]   a_val;
	logic [W-1:0]   b_reg;
	logic [W-1:0]   b_val;
	logic [W-1:0]   diff;
	logic [W-1:0]   alu;
	logic           dp_ok;
	logic           is_cmp;
	logic           is_store;
	logic           is_load;
	logic           wr_en;
	logic [W-1:0]   wr_val;
	logic           taken;
	logic [W-1:0]   br_off;
	logic [W-1:0]   next_pc;
	logic           stop;

	logic           rf_we;
	logic           dm_we;
	logic [SAW-1:0] dm_waddr;
	logic [W-1:0]   dm_wdata;

	assign fire          = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !clr_busy_q && (!s1_valid_q || fire);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign in_cls     = s_axis_tdata[27:26];
	assign in_addr_a  = (in_cls == asis_pkg::CLS_MEM) ? s_axis_tdata[15:12] : s_axis_tdata[19:16];
	assign in_addr_b  = s_axis_tdata[3:0];
	assign in_dm_addr = {s_axis_tdata[19:16], s_axis_tdata[BAW+1:2]};

	assign cls     = instr_s1[27:26];
	assign rn      = instr_s1[19:16];
	assign rd      = instr_s1[15:12];
	assign rm      = instr_s1[3:0];
	assign addr_a  = (cls == asis_pkg::CLS_MEM) ? rd : rn;
	assign op_dp   = instr_s1[24:21];
	assign op_ls   = instr_s1[25:20];
	assign cond    = instr_s1[31:28];
	assign dm_addr = {rn, instr_s1[BAW+1:2]};

	assign pc_plus1 = pc_q + 32'd1;
	assign a_val    = operand(addr_a, byp_a_s1, vld_a_s1, rf_a_rdata, byp_val_s1, pc_plus1);
	assign b_reg    = operand(rm, byp_b_s1, vld_b_s1, rf_b_rdata, byp_val_s1, pc_plus1);
	assign b_val    = instr_s1[25] ? {24'd0, instr_s1[7:0]} : b_reg;
	assign diff     = a_val - b_val;

	always_comb begin
		dp_ok = 1'b1;
		alu   = '0;
		unique case (op_dp)
			asis_pkg::OP_AND: alu = a_val & b_val;
			asis_pkg::OP_SUB: alu = diff;
			asis_pkg::OP_ADD: alu = a_val + b_val;
			asis_pkg::OP_ORR: alu = a_val | b_val;
			asis_pkg::OP_MOV: alu = b_val;
			asis_pkg::OP_MVN: alu = ~b_val;
			default:          dp_ok = 1'b0;
		endcase
	end

	assign is_cmp   = (cls == asis_pkg::CLS_DP) && (op_dp == asis_pkg::OP_CMP);
	assign is_store = (cls == asis_pkg::CLS_MEM) && (op_ls == asis_pkg::LS_STORE);
	assign is_load  = (cls == asis_pkg::CLS_MEM) && (op_ls == asis_pkg::LS_LOAD);

	// A load may target R0; a data-processing result for R0 is dropped.
	assign wr_en  = is_load ||
		((cls == asis_pkg::CLS_DP) && dp_ok && (rd != asis_pkg::ZERO_INDEX));
	assign wr_val = is_load ? (st_byp_s1 ? st_byp_val_s1 : dm_rdata) : alu;

	always_comb begin
		unique case (cond)
			asis_pkg::COND_EQ: taken = z_q;
			asis_pkg::COND_NE: taken = !z_q;
			asis_pkg::COND_GE: taken = !n_q;
			asis_pkg::COND_LT: taken = n_q;
			asis_pkg::COND_GT: taken = !z_q && !n_q;
			asis_pkg::COND_LE: taken = n_q || z_q;
			asis_pkg::COND_AL: taken = 1'b1;
			default:           taken = 1'b0;
		endcase
	end

	assign br_off = {{8{instr_s1[23]}}, instr_s1[23:0]};

	always_comb begin
		priority if (wr_en && (rd == asis_pkg::PC_INDEX)) begin
			next_pc = wr_val;
		end else if ((cls == asis_pkg::CLS_BR) && taken) begin
			next_pc = pc_plus1 + 32'd1 + br_off;
		end else begin
			next_pc = pc_plus1;
		end
	end

	assign stop = (instr_s1 == asis_pkg::EXIT_WORD);

	assign rf_we    = fire && wr_en;
	assign dm_we    = clr_busy_q || (fire && is_store);
	assign dm_waddr = clr_busy_q ? clr_cnt_q : dm_addr;
	assign dm_wdata = clr_busy_q ? '0 : a_val;

	// Two copies of the register file give the two read ports.
	asis_ram #(.WIDTH(W), .DEPTH(asis_pkg::REGS)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rd),
		.wdata (wr_val),
		.re    (accept),
		.raddr (in_addr_a),
		.rdata (rf_a_rdata)
	);

	asis_ram #(.WIDTH(W), .DEPTH(asis_pkg::REGS)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rd),
		.wdata (wr_val),
		.re    (accept),
		.raddr (in_addr_b),
		.rdata (rf_b_rdata)
	);

	asis_ram #(.WIDTH(W), .DEPTH(asis_pkg::STORE_WORDS)) u_dstore (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.re    (accept),
		.raddr (in_dm_addr),
		.rdata (dm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
			n_q         <= 1'b0;
			z_q         <= 1'b0;
			rf_valid_q  <= '0;
			clr_busy_q  <= 1'b1;
			clr_cnt_q   <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				pc_q <= next_pc;
				if (is_cmp) begin
					n_q <= diff[W-1];
					z_q <= (a_val == b_val);
				end
			end
			if (rf_we) begin
				rf_valid_q[rd] <= 1'b1;
			end
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + SAW'(1);
				if (clr_cnt_q == SAW'(asis_pkg::STORE_WORDS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	// A write retiring in the same cycle as the read is not yet in the RAM, so it is bypassed.
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1      <= s_axis_tdata;
			vld_a_s1      <= rf_valid_q[in_addr_a];
			vld_b_s1      <= rf_valid_q[in_addr_b];
			byp_a_s1      <= rf_we && (rd == in_addr_a);
			byp_b_s1      <= rf_we && (rd == in_addr_b);
			byp_val_s1    <= wr_val;
			st_byp_s1     <= fire && is_store && (dm_addr == in_dm_addr);
			st_byp_val_s1 <= a_val;
		end
		if (fire) begin
			out_data_q <= {{PADW{1'b0}}, (wr_en ? wr_val : {W{1'b0}}),
				(wr_en ? rd : {RAW{1'b0}}), next_pc};
			out_user_q <= wr_en;
			out_last_q <= stop;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule

[design/asis_ram.sv]
module asis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/asis_checker.sv]
module asis_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [asis_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                             m_axis_tuser,
	input logic                             m_axis_tlast
);

	localparam int IL = asis_pkg::OUT_IDX_LSB;
	localparam int VL = asis_pkg::OUT_VAL_LSB;
	localparam int W  = asis_pkg::WORD_W;
	localparam int RAW = asis_pkg::REG_AW;

	logic [W-1:0]   out_pc;
	logic [RAW-1:0] out_idx;
	logic [W-1:0]   out_val;

	assign out_pc  = m_axis_tdata[IL-1:0];
	assign out_idx = m_axis_tdata[VL-1:IL];
	assign out_val = m_axis_tdata[VL+W-1:VL];

	// The exit call is a software call and never writes a register.
	a_exit_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
		else $error("exit call transfer reports a register write");

	// Without a write, the index and value fields are zero.
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (out_idx == '0) && (out_val == '0))
		else $error("write fields not zero on a transfer without a write");

	// A write to the program counter is the next fetch address.
	a_pc_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser && (out_idx == asis_pkg::PC_INDEX) |-> (out_pc == out_val))
		else $error("write to R15 does not match the next fetch address");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule

bind arm_subset_instruction_step asis_checker u_asis_checker (.*);
